// ===== rtl/core/icet_pkg.sv =====
// Shared types, codes and constants for the input event capture trigger.
package icet_pkg;

    // Input commands, carried in s_tuser
    localparam logic [1:0] CMD_ARM  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Capture modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_REACTION = 2'd1;
    localparam logic [1:0] MODE_RISING   = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_CAPTURE_MODE      = 2'd0;
    localparam logic [1:0] REG_STICK_THRESHOLD   = 2'd1;
    localparam logic [1:0] REG_TRIGGER_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_STICK_SELECT      = 2'd3;

    // Reset values of the thresholds
    localparam logic [7:0] STICK_THR_RESET   = 8'd23;
    localparam logic [7:0] TRIGGER_THR_RESET = 8'd49;

    // Stick centre, and the end position meaning "not yet triggered"
    localparam logic [7:0] STICK_CENTER = 8'd127;
    localparam logic [7:0] TAIL_IDLE    = 8'd255;

    // Button masks for reaction timing
    localparam logic [7:0] REACT_MASK_LOW  = 8'b0000_1111;
    localparam logic [7:0] REACT_MASK_HIGH = 8'b0111_1111;

    // Ring positions are kept at this width
    localparam int POS_W = 8;

    // One input item, last field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic [7:0] unfilt_y;
        logic [7:0] unfilt_x;
        logic [7:0] right_trigger;
        logic [7:0] left_trigger;
        logic [7:0] c_y;
        logic [7:0] c_x;
        logic [7:0] main_y;
        logic [7:0] main_x;
        logic [7:0] buttons_high;
        logic [7:0] buttons_low;
        logic [6:0] read_index;
    } in_item_t;

    // One stored ring entry
    typedef struct packed {
        logic [7:0] buttons;
        logic [7:0] unfilt_y;
        logic [7:0] unfilt_x;
        logic [7:0] y;
        logic [7:0] x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result item, last field in the lowest bits
    typedef struct packed {
        entry_t      entry;
        logic [7:0]  end_pos;
        logic [6:0]  start_pos;
        logic [15:0] reaction_count;
        logic        capture_done;
    } out_item_t;

    // Absolute difference of two bytes
    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/core/icet_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module icet_ram
#(
    parameter int WIDTH = 40,
    parameter int DEPTH = 100,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, hold data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/input_event_capture_trigger.sv =====
// Top level of the input event capture trigger: config, state update, ring and output stage.
//
//  channel  direction  handshake           payload
//  s_axis   in         s_tvalid/s_tready   s_tdata (item fields), s_tuser (cmd)
//  m_axis   out        m_tvalid/m_tready   m_tdata (status and read entry)
//  apb      in/out     psel/penable/pready paddr, pwdata, prdata
//
//  One item per cycle while the output is not stalled; each result appears in the cycle after its transfer.
//  State and the ring write update at the input transfer edge; the ring read
//  is registered in the same edge and lands in the output stage.
//  Reset returns control state to its reset values; ring contents are undefined until written.
//  A stalled output holds and blocks new input until it is taken.
module input_event_capture_trigger
    import icet_pkg::*;
#(
    parameter int DEPTH = 100
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] read_index, [14:7] buttons_low, [22:15] buttons_high, [30:23] main_x,
    // [38:31] main_y, [46:39] c_x, [54:47] c_y, [62:55] left_trigger,
    // [70:63] right_trigger, [78:71] unfilt_x, [86:79] unfilt_y, [87] zero
    input  logic [87:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] capture_done, [16:1] reaction_count, [23:17] start_pos, [31:24] end_pos,
    // [39:32] entry_x, [47:40] entry_y, [55:48] entry_unfilt_x,
    // [63:56] entry_unfilt_y, [71:64] entry_buttons
    output logic [71:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DEPTH - 1);
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

    in_item_t in_item;
    logic     s_xfer;
    logic     cfg_write;
    logic [1:0] reg_sel;

    // Configuration registers
    logic [1:0] capture_mode_reg;
    logic [7:0] stick_threshold_reg;
    logic [7:0] trigger_threshold_reg;
    logic       stick_select_reg;

    // Capture state
    logic [7:0]       origin_x_reg,     origin_x_next;
    logic [7:0]       origin_y_reg,     origin_y_next;
    logic             begun_reg,        begun_next;
    logic             finished_reg,     finished_next;
    logic [15:0]      sample_count_reg, sample_count_next;
    logic [POS_W-1:0] head_reg,         head_next;
    logic [POS_W-1:0] tail_reg,         tail_next;

    // Output stage
    logic out_valid_reg, out_valid_next;
    logic entry_ok_reg;

    // Ring access
    logic             ram_we;
    logic [POS_W-1:0] ram_wpos;
    entry_t           wr_entry;
    logic             read_ok;
    logic [POS_W-1:0] read_pos;
    logic [ENTRY_W-1:0] ram_rdata;

    // Selected stick and derived conditions
    logic [7:0]       sel_x, sel_y;
    logic             react_hit;
    logic             moved;
    logic [POS_W-1:0] head_inc;
    logic [POS_W-1:0] tail_inc;
    logic [POS_W-1:0] head_inc_inc;

    out_item_t out_item;

    assign in_item = in_item_t'(s_tdata);
    assign s_tready = !out_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    // Configuration port: writes in the access phase, reads by word index
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capture_mode_reg      <= MODE_IDLE;
            stick_threshold_reg   <= STICK_THR_RESET;
            trigger_threshold_reg <= TRIGGER_THR_RESET;
            stick_select_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_CAPTURE_MODE:      capture_mode_reg      <= pwdata[1:0];
                REG_STICK_THRESHOLD:   stick_threshold_reg   <= pwdata[7:0];
                REG_TRIGGER_THRESHOLD: trigger_threshold_reg <= pwdata[7:0];
                REG_STICK_SELECT:      stick_select_reg      <= pwdata[0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CAPTURE_MODE:      prdata = {30'd0, capture_mode_reg};
            REG_STICK_THRESHOLD:   prdata = {24'd0, stick_threshold_reg};
            REG_TRIGGER_THRESHOLD: prdata = {24'd0, trigger_threshold_reg};
            REG_STICK_SELECT:      prdata = {31'd0, stick_select_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // Pick the captured stick and build the entry to store
    assign sel_x = stick_select_reg ? in_item.c_x : in_item.main_x;
    assign sel_y = stick_select_reg ? in_item.c_y : in_item.main_y;

    assign wr_entry.x        = sel_x;
    assign wr_entry.y        = sel_y;
    assign wr_entry.unfilt_x = in_item.unfilt_x;
    assign wr_entry.unfilt_y = in_item.unfilt_y;
    assign wr_entry.buttons  = {in_item.buttons_high[6:4], in_item.buttons_low[4:0]};

    // Reaction end: masked button, stick deviation or trigger level
    assign react_hit =
        ((in_item.buttons_low & REACT_MASK_LOW) != 8'd0) ||
        ((in_item.buttons_high & REACT_MASK_HIGH) != 8'd0) ||
        (abs_diff(in_item.main_x, STICK_CENTER) >= stick_threshold_reg) ||
        (abs_diff(in_item.main_y, STICK_CENTER) >= stick_threshold_reg) ||
        (abs_diff(in_item.c_x, STICK_CENTER) >= stick_threshold_reg) ||
        (abs_diff(in_item.c_y, STICK_CENTER) >= stick_threshold_reg) ||
        (in_item.left_trigger >= trigger_threshold_reg) ||
        (in_item.right_trigger >= trigger_threshold_reg);

    // Rising-stick trigger: leaves the origin by more than the threshold
    assign moved = (abs_diff(sel_x, origin_x_reg) > stick_threshold_reg) ||
                   (abs_diff(sel_y, origin_y_reg) > stick_threshold_reg);

    // Ring position increments with wrap
    assign head_inc     = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
    assign tail_inc     = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
    assign head_inc_inc = (head_inc == LAST_POS) ? '0 : head_inc + 1'b1;

    // Next capture state and ring write for one item
    always_comb
    begin
        origin_x_next     = origin_x_reg;
        origin_y_next     = origin_y_reg;
        begun_next        = begun_reg;
        finished_next     = finished_reg;
        sample_count_next = sample_count_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        ram_we            = 1'b0;
        ram_wpos          = '0;

        if (s_xfer)
        begin
            if (s_tuser == CMD_ARM)
            begin
                begun_next        = 1'b0;
                finished_next     = 1'b0;
                sample_count_next = 16'd0;
            end
            else if (s_tuser == CMD_TICK && !finished_reg)
            begin
                if (capture_mode_reg == MODE_REACTION)
                begin
                    if (sample_count_reg != 16'hFFFF)
                    begin
                        sample_count_next = sample_count_reg + 16'd1;
                    end
                    if (react_hit)
                    begin
                        finished_next = 1'b1;
                    end
                end
                else if (capture_mode_reg == MODE_RISING)
                begin
                    if (!begun_reg)
                    begin
                        begun_next    = 1'b1;
                        head_next     = '0;
                        tail_next     = TAIL_IDLE;
                        origin_x_next = sel_x;
                        origin_y_next = sel_y;
                        ram_we        = 1'b1;
                        ram_wpos      = '0;
                    end
                    else if (tail_reg == TAIL_IDLE)
                    begin
                        head_next = head_inc;
                        ram_we    = 1'b1;
                        ram_wpos  = head_inc;
                        if (moved)
                        begin
                            tail_next = head_inc_inc;
                        end
                    end
                    else if (tail_reg != head_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wpos  = tail_reg;
                        tail_next = tail_inc;
                    end
                    else
                    begin
                        finished_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold capture state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= 8'd0;
            origin_y_reg     <= 8'd0;
            begun_reg        <= 1'b0;
            finished_reg     <= 1'b1;
            sample_count_reg <= 16'd0;
            head_reg         <= '0;
            tail_reg         <= '0;
        end
        else
        begin
            origin_x_reg     <= origin_x_next;
            origin_y_reg     <= origin_y_next;
            begun_reg        <= begun_next;
            finished_reg     <= finished_next;
            sample_count_reg <= sample_count_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
        end
    end

    // Ring read for a read command within range
    assign read_pos = {1'b0, in_item.read_index};
    assign read_ok  = (s_tuser == CMD_READ) && (read_pos < DEPTH_POS);

    icet_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_wpos[AW-1:0]),
        .wdata (wr_entry),
        .re    (s_xfer && read_ok),
        .raddr (read_pos[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Output stage: load on each input transfer, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s_xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            entry_ok_reg <= read_ok;
        end
    end

    // Status comes straight from the state: it only moves on an input transfer,
    // which also reloads the output stage
    assign out_item.capture_done   = finished_reg;
    assign out_item.reaction_count = sample_count_reg;
    assign out_item.start_pos      = head_reg[6:0];
    assign out_item.end_pos        = tail_reg;
    assign out_item.entry          = entry_ok_reg ? entry_t'(ram_rdata) : '0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item;

    // Ring head always lies inside the ring
    assert property (@(posedge clk) disable iff (!rst_n) head_reg < DEPTH_POS)
        else $error("ring head out of range");

    // Tail is inside the ring or marks "not yet triggered"
    assert property (@(posedge clk) disable iff (!rst_n)
        (tail_reg < DEPTH_POS) || (tail_reg == TAIL_IDLE))
        else $error("ring tail out of range");

    // Ring writes happen only on a sample tick transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (s_xfer && s_tuser == CMD_TICK && capture_mode_reg == MODE_RISING))
        else $error("ring write without a tick");

    // Arm clears the done flag and the count
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && s_tuser == CMD_ARM) |=> (!finished_reg && sample_count_reg == 16'd0))
        else $error("arm did not clear state");

    // State holds while a result waits to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=>
            ($stable(head_reg) && $stable(tail_reg) && $stable(finished_reg)))
        else $error("state moved during output stall");

endmodule
